>>> rtl/core/vo_residual_jacobian_macros.svh
// assertion macros for the residual and jacobian block
// expects clk and rst_n in the scope of use
`ifndef VO_RESIDUAL_JACOBIAN_MACROS_SVH
`define VO_RESIDUAL_JACOBIAN_MACROS_SVH

// same-cycle implication
`define VRJ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vrj check failed");

// next-cycle implication
`define VRJ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vrj check failed");

`endif

>>> rtl/core/vrj_pkg.sv
// shared types, constants and saturating helpers for the residual/jacobian block
// no dependencies
package vrj_pkg;

  typedef logic signed [47:0] q_t;
  typedef logic signed [33:0] rot_t;
  typedef rot_t [2:0][2:0] rmat_t;

  localparam q_t SAT_MAX = {1'b0, {47{1'b1}}};
  localparam q_t SAT_MIN = {1'b1, {47{1'b0}}};
  localparam q_t ONE_Q16 = 48'sd65536;
  localparam logic signed [31:0] QUAT_POS = 32'sd1073741824;
  localparam logic signed [31:0] QUAT_NEG = -32'sd1073741824;

  localparam int MUL_LAT = 3;
  localparam int N_L1 = 13;
  localparam int N_L2 = 27;
  localparam int N_L3 = 10;

  localparam logic OP_EPI  = 1'b0;
  localparam logic OP_REPR = 1'b1;

  localparam logic [1:0] KIND_EPI = 2'd0;
  localparam logic [1:0] KIND_X   = 2'd1;
  localparam logic [1:0] KIND_Y   = 2'd2;

  localparam logic [2:0] CFG_TX = 3'd0;
  localparam logic [2:0] CFG_TY = 3'd1;
  localparam logic [2:0] CFG_TZ = 3'd2;
  localparam logic [2:0] CFG_QX = 3'd3;
  localparam logic [2:0] CFG_QY = 3'd4;
  localparam logic [2:0] CFG_QZ = 3'd5;
  localparam logic [2:0] CFG_QW = 3'd6;

  typedef struct packed {
    logic              opcode;
    logic signed [31:0] src_u;
    logic signed [31:0] src_v;
    logic signed [31:0] src_depth;
    logic signed [31:0] dst_u;
    logic signed [31:0] dst_v;
  } in_t;

  typedef struct packed {
    logic [1:0] row_kind;
    q_t         residual;
    q_t         d_tx;
    q_t         d_ty;
    q_t         d_tz;
    q_t         d_rx;
    q_t         d_ry;
    q_t         d_rz;
    logic       last;
  } out_t;

  // everything an item carries down the pipe
  typedef struct packed {
    logic       op;
    q_t         u1;
    q_t         v1;
    q_t [2:0]   x;
    q_t [2:0]   s;
    q_t [2:0]   tp;
    q_t [8:0]   c;
    out_t       ra;
    out_t       rb;
  } ctx_t;

  function automatic q_t sat_add(q_t a, q_t b);
    logic signed [48:0] s;
    s = 49'(a) + 49'(b);
    if (s[48] != s[47]) return s[48] ? SAT_MIN : SAT_MAX;
    return s[47:0];
  endfunction

  function automatic q_t sat_sub(q_t a, q_t b);
    logic signed [48:0] s;
    s = 49'(a) - 49'(b);
    if (s[48] != s[47]) return s[48] ? SAT_MIN : SAT_MAX;
    return s[47:0];
  endfunction

  function automatic q_t ext32(logic signed [31:0] v);
    return {{16{v[31]}}, v};
  endfunction

  function automatic q_t ext_r(rot_t v);
    return {{14{v[33]}}, v};
  endfunction

  function automatic logic signed [31:0] clamp_q(logic signed [31:0] v);
    if (v > QUAT_POS) return QUAT_POS;
    if (v < QUAT_NEG) return QUAT_NEG;
    return v;
  endfunction

endpackage

>>> rtl/core/vrj_mul.sv
// three-stage 48x48 signed fractional multiplier, floor and saturate to q32.16
// depends on vrj_pkg
module vrj_mul (
  input  logic         clk,
  input  vrj_pkg::q_t  a,
  input  vrj_pkg::q_t  b,
  input  logic         sel30,
  output vrj_pkg::q_t  p
);

  logic [47:0] ua, ub;
  logic [47:0] pp_r [4];
  logic        neg1_r, sel1_r, neg2_r, sel2_r;
  logic [95:0] prod_r, q, qq;
  logic        rem;
  vrj_pkg::q_t p_r, p_nxt;

  assign ua = a[47] ? 48'(-a) : a;
  assign ub = b[47] ? 48'(-b) : b;

  // partial products of 24-bit halves
  always_ff @(posedge clk) begin
    pp_r[0] <= ua[23:0] * ub[23:0];
    pp_r[1] <= ua[23:0] * ub[47:24];
    pp_r[2] <= ua[47:24] * ub[23:0];
    pp_r[3] <= ua[47:24] * ub[47:24];
    neg1_r  <= a[47] ^ b[47];
    sel1_r  <= sel30;
  end

  always_ff @(posedge clk) begin
    prod_r <= {48'd0, pp_r[0]} + ({48'd0, pp_r[1]} << 24) + ({48'd0, pp_r[2]} << 24)
            + {pp_r[3], 48'd0};
    neg2_r <= neg1_r;
    sel2_r <= sel1_r;
  end

  always_comb begin
    q   = sel2_r ? (prod_r >> 30) : (prod_r >> 16);
    rem = sel2_r ? (|prod_r[29:0]) : (|prod_r[15:0]);
    qq  = q + 96'(rem);
    if (!neg2_r) begin
      p_nxt = (q > 96'h7FFF_FFFF_FFFF) ? vrj_pkg::SAT_MAX : q[47:0];
    end else begin
      p_nxt = (qq > 96'h8000_0000_0000) ? vrj_pkg::SAT_MIN : 48'(-qq[47:0]);
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  assign p = p_r;

endmodule

>>> rtl/core/vrj_mulbank.sv
// bank of multipliers for one pipeline level, with the item context delayed alongside
// depends on vrj_pkg and vrj_mul
module vrj_mulbank #(
  parameter int N = vrj_pkg::N_L1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_in,
  input  vrj_pkg::ctx_t ctx_in,
  input  vrj_pkg::q_t   a [N],
  input  vrj_pkg::q_t   b [N],
  input  logic [N-1:0]  sel30,
  output vrj_pkg::q_t   p [N],
  output logic          valid_out,
  output vrj_pkg::ctx_t ctx_out
);

  vrj_pkg::ctx_t ctx_r [vrj_pkg::MUL_LAT];
  logic [vrj_pkg::MUL_LAT-1:0] vld_r;

  for (genvar i = 0; i < N; i++) begin : g_mul
    vrj_mul u_mul (
      .clk   (clk),
      .a     (a[i]),
      .b     (b[i]),
      .sel30 (sel30[i]),
      .p     (p[i])
    );
  end

  always_ff @(posedge clk) begin
    ctx_r[0] <= ctx_in;
    for (int i = 1; i < vrj_pkg::MUL_LAT; i++) ctx_r[i] <= ctx_r[i-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[vrj_pkg::MUL_LAT-2:0], valid_in};
    end
  end

  assign valid_out = vld_r[vrj_pkg::MUL_LAT-1];
  assign ctx_out   = ctx_r[vrj_pkg::MUL_LAT-1];

endmodule

>>> rtl/core/vrj_rot.sv
// rotation matrix as q4.30 from the q2.30 quaternion registers, one register stage
// depends on vrj_pkg
module vrj_rot (
  input  logic               clk,
  input  logic signed [31:0] quat_x,
  input  logic signed [31:0] quat_y,
  input  logic signed [31:0] quat_z,
  input  logic signed [31:0] quat_w,
  output vrj_pkg::rmat_t     rot
);

  localparam logic signed [65:0] ONE60 = 66'sd1 <<< 60;

  logic signed [31:0] x, y, z, w;
  logic signed [63:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
  logic signed [65:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  vrj_pkg::rmat_t rot_r, rot_nxt;

  always_comb begin
    x  = vrj_pkg::clamp_q(quat_x);
    y  = vrj_pkg::clamp_q(quat_y);
    z  = vrj_pkg::clamp_q(quat_z);
    w  = vrj_pkg::clamp_q(quat_w);
    xx = x * x;  yy = y * y;  zz = z * z;
    xy = x * y;  xz = x * z;  yz = y * z;
    xw = x * w;  yw = y * w;  zw = z * w;
    e00 = ONE60 - ((66'(yy) + 66'(zz)) <<< 1);
    e01 = (66'(xy) - 66'(zw)) <<< 1;
    e02 = (66'(xz) + 66'(yw)) <<< 1;
    e10 = (66'(xy) + 66'(zw)) <<< 1;
    e11 = ONE60 - ((66'(xx) + 66'(zz)) <<< 1);
    e12 = (66'(yz) - 66'(xw)) <<< 1;
    e20 = (66'(xz) - 66'(yw)) <<< 1;
    e21 = (66'(yz) + 66'(xw)) <<< 1;
    e22 = ONE60 - ((66'(xx) + 66'(yy)) <<< 1);
    // floor by 2^30
    rot_nxt[0][0] = e00[63:30]; rot_nxt[0][1] = e01[63:30]; rot_nxt[0][2] = e02[63:30];
    rot_nxt[1][0] = e10[63:30]; rot_nxt[1][1] = e11[63:30]; rot_nxt[1][2] = e12[63:30];
    rot_nxt[2][0] = e20[63:30]; rot_nxt[2][1] = e21[63:30]; rot_nxt[2][2] = e22[63:30];
  end

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
  end

  assign rot = rot_r;

endmodule

>>> rtl/core/vo_residual_jacobian.sv
// epipolar / reprojection residual and jacobian rows for one feature match
// results pass the entry registers, three multiplier levels and the output register
// throughput: a match without depth every cycle while busy is low; a match with depth holds off the next one
// (busy is high for one cycle after a match with depth is taken)
// results are strobed out_valid for one cycle and cannot be held off by the receiver
// reset (rst_n low, synchronous) empties the pipe and loads the identity pose
`include "vo_residual_jacobian_macros.svh"

module vo_residual_jacobian (
  input  logic           clk,
  input  logic           rst_n,
  // input transactions
  input  logic           start,
  output logic           busy,
  input  vrj_pkg::in_t   in_item,
  // result transactions
  output logic           out_valid,
  output vrj_pkg::out_t  out_item,
  // configuration writes
  input  logic           cfg_we,
  input  logic [2:0]     cfg_idx,
  input  logic [31:0]    cfg_wdata
);

  // pose registers
  logic signed [31:0] trans_x_r, trans_y_r, trans_z_r;
  logic signed [31:0] quat_x_r, quat_y_r, quat_z_r, quat_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_x_r <= '0;
      trans_y_r <= '0;
      trans_z_r <= '0;
      quat_x_r  <= '0;
      quat_y_r  <= '0;
      quat_z_r  <= '0;
      quat_w_r  <= vrj_pkg::QUAT_POS;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        vrj_pkg::CFG_TX: trans_x_r <= cfg_wdata;
        vrj_pkg::CFG_TY: trans_y_r <= cfg_wdata;
        vrj_pkg::CFG_TZ: trans_z_r <= cfg_wdata;
        vrj_pkg::CFG_QX: quat_x_r  <= cfg_wdata;
        vrj_pkg::CFG_QY: quat_y_r  <= cfg_wdata;
        vrj_pkg::CFG_QZ: quat_z_r  <= cfg_wdata;
        vrj_pkg::CFG_QW: quat_w_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // rotation matrix, registered in vrj_rot from the quaternion registers
  vrj_pkg::rmat_t rot;
  vrj_pkg::q_t    rm [3][3];
  vrj_pkg::q_t    tx, ty, tz;

  vrj_rot u_rot (
    .clk    (clk),
    .quat_x (quat_x_r),
    .quat_y (quat_y_r),
    .quat_z (quat_z_r),
    .quat_w (quat_w_r),
    .rot    (rot)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) rm[k][j] = vrj_pkg::ext_r(rot[k][j]);
    end
  end

  assign tx = vrj_pkg::ext32(trans_x_r);
  assign ty = vrj_pkg::ext32(trans_y_r);
  assign tz = vrj_pkg::ext32(trans_z_r);

  // input handshake: a depth match takes two output slots, so busy holds off the next match
  logic accept;
  logic busy_r;

  assign accept = start && !busy;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= accept && (in_item.opcode == vrj_pkg::OP_REPR);
    end
  end

  // entry registers: the second one also covers the rotation register latency
  vrj_pkg::in_t  in_r;
  logic          in_v_r;
  vrj_pkg::ctx_t ctx0_r, ctx0_nxt;
  logic          v0_r;

  always_comb begin
    ctx0_nxt      = '0;
    ctx0_nxt.op   = in_r.opcode;
    ctx0_nxt.u1   = vrj_pkg::ext32(in_r.dst_u);
    ctx0_nxt.v1   = vrj_pkg::ext32(in_r.dst_v);
    ctx0_nxt.x[0] = vrj_pkg::ext32(in_r.src_u);
    ctx0_nxt.x[1] = vrj_pkg::ext32(in_r.src_v);
    ctx0_nxt.x[2] = (in_r.opcode == vrj_pkg::OP_REPR) ? vrj_pkg::ext32(in_r.src_depth)
                                                      : vrj_pkg::ONE_Q16;
  end

  always_ff @(posedge clk) begin
    if (accept) in_r <= in_item;
    ctx0_r <= ctx0_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      v0_r   <= 1'b0;
    end else begin
      in_v_r <= accept;
      v0_r   <= in_v_r;
    end
  end

  // ---------------------------------------------------------------------
  // level 1: epipolar R*p0 and t x p1 products, or the scaled ray for depth
  // ---------------------------------------------------------------------
  vrj_pkg::q_t a1 [vrj_pkg::N_L1];
  vrj_pkg::q_t b1 [vrj_pkg::N_L1];
  vrj_pkg::q_t p1 [vrj_pkg::N_L1];
  logic [vrj_pkg::N_L1-1:0] s1;
  vrj_pkg::ctx_t c1d, ctx1_r, ctx1_nxt;
  logic          v1d, v1_r;

  always_comb begin
    for (int i = 0; i < vrj_pkg::N_L1; i++) begin
      a1[i] = '0;
      b1[i] = '0;
    end
    s1 = '0;
    if (ctx0_r.op == vrj_pkg::OP_EPI) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          a1[3*k+j] = rm[k][j];
          b1[3*k+j] = ctx0_r.x[j];
          s1[3*k+j] = 1'b1;
        end
      end
      a1[9]  = tz;        b1[9]  = ctx0_r.v1;
      a1[10] = ctx0_r.u1; b1[10] = tz;
      a1[11] = ctx0_r.v1; b1[11] = tx;
      a1[12] = ctx0_r.u1; b1[12] = ty;
    end else begin
      a1[0] = ctx0_r.x[0]; b1[0] = ctx0_r.x[2];
      a1[1] = ctx0_r.x[1]; b1[1] = ctx0_r.x[2];
    end
  end

  vrj_mulbank #(.N(vrj_pkg::N_L1)) u_bank1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (v0_r),
    .ctx_in    (ctx0_r),
    .a         (a1),
    .b         (b1),
    .sel30     (s1),
    .p         (p1),
    .valid_out (v1d),
    .ctx_out   (c1d)
  );

  always_comb begin
    ctx1_nxt = c1d;
    if (c1d.op == vrj_pkg::OP_EPI) begin
      // s = R p0, tp = t x p1
      for (int k = 0; k < 3; k++) begin
        ctx1_nxt.s[k] = vrj_pkg::sat_add(vrj_pkg::sat_add(p1[3*k], p1[3*k+1]), p1[3*k+2]);
      end
      ctx1_nxt.tp[0] = vrj_pkg::sat_sub(ty, p1[9]);
      ctx1_nxt.tp[1] = vrj_pkg::sat_sub(p1[10], tx);
      ctx1_nxt.tp[2] = vrj_pkg::sat_sub(p1[11], p1[12]);
    end else begin
      // X = (u0*d, v0*d, d)
      ctx1_nxt.x[0] = p1[0];
      ctx1_nxt.x[1] = p1[1];
    end
  end

  always_ff @(posedge clk) begin
    ctx1_r <= ctx1_nxt;
  end

  // ---------------------------------------------------------------------
  // level 2: epipolar residual, d_t terms and R^T tp, or R X and three cross products
  // ---------------------------------------------------------------------
  vrj_pkg::q_t a2 [vrj_pkg::N_L2];
  vrj_pkg::q_t b2 [vrj_pkg::N_L2];
  vrj_pkg::q_t p2 [vrj_pkg::N_L2];
  logic [vrj_pkg::N_L2-1:0] s2;
  vrj_pkg::ctx_t c2d, ctx2_r, ctx2_nxt;
  logic          v2d, v2_r;

  always_comb begin
    for (int i = 0; i < vrj_pkg::N_L2; i++) begin
      a2[i] = '0;
      b2[i] = '0;
    end
    s2 = '0;
    if (ctx1_r.op == vrj_pkg::OP_EPI) begin
      for (int k = 0; k < 3; k++) begin
        a2[k] = ctx1_r.tp[k];
        b2[k] = ctx1_r.s[k];
      end
      a2[3] = ctx1_r.v1; b2[3] = ctx1_r.s[2];
      a2[4] = ctx1_r.u1; b2[4] = ctx1_r.s[2];
      a2[5] = ctx1_r.u1; b2[5] = ctx1_r.s[1];
      a2[6] = ctx1_r.v1; b2[6] = ctx1_r.s[0];
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          a2[7+3*k+j] = rm[j][k];
          b2[7+3*k+j] = ctx1_r.tp[j];
          s2[7+3*k+j] = 1'b1;
        end
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          a2[3*k+j] = rm[k][j];
          b2[3*k+j] = ctx1_r.x[j];
        end
      end
      // X x row m of R
      for (int m = 0; m < 3; m++) begin
        a2[9+6*m]   = ctx1_r.x[1]; b2[9+6*m]   = rm[m][2];
        a2[10+6*m]  = ctx1_r.x[2]; b2[10+6*m]  = rm[m][1];
        a2[11+6*m]  = ctx1_r.x[2]; b2[11+6*m]  = rm[m][0];
        a2[12+6*m]  = ctx1_r.x[0]; b2[12+6*m]  = rm[m][2];
        a2[13+6*m]  = ctx1_r.x[0]; b2[13+6*m]  = rm[m][1];
        a2[14+6*m]  = ctx1_r.x[1]; b2[14+6*m]  = rm[m][0];
      end
      s2 = '1;
    end
  end

  vrj_mulbank #(.N(vrj_pkg::N_L2)) u_bank2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (v1_r),
    .ctx_in    (ctx1_r),
    .a         (a2),
    .b         (b2),
    .sel30     (s2),
    .p         (p2),
    .valid_out (v2d),
    .ctx_out   (c2d)
  );

  always_comb begin
    ctx2_nxt = c2d;
    if (c2d.op == vrj_pkg::OP_EPI) begin
      ctx2_nxt.ra.residual = vrj_pkg::sat_add(vrj_pkg::sat_add(p2[0], p2[1]), p2[2]);
      ctx2_nxt.ra.d_tx     = vrj_pkg::sat_sub(p2[3], c2d.s[1]);
      ctx2_nxt.ra.d_ty     = vrj_pkg::sat_sub(c2d.s[0], p2[4]);
      ctx2_nxt.ra.d_tz     = vrj_pkg::sat_sub(p2[5], p2[6]);
      // w = R^T tp kept in the first three cross slots
      for (int k = 0; k < 3; k++) begin
        ctx2_nxt.c[k] = vrj_pkg::sat_add(vrj_pkg::sat_add(p2[7+3*k], p2[8+3*k]), p2[9+3*k]);
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        ctx2_nxt.s[k] = vrj_pkg::sat_add(vrj_pkg::sat_add(p2[3*k], p2[3*k+1]), p2[3*k+2]);
      end
      for (int m = 0; m < 3; m++) begin
        for (int n = 0; n < 3; n++) begin
          ctx2_nxt.c[3*m+n] = vrj_pkg::sat_sub(p2[9+6*m+2*n], p2[10+6*m+2*n]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    ctx2_r <= ctx2_nxt;
  end

  // ---------------------------------------------------------------------
  // level 3: epipolar rotation derivatives, or both reprojection rows
  // ---------------------------------------------------------------------
  vrj_pkg::q_t a3 [vrj_pkg::N_L3];
  vrj_pkg::q_t b3 [vrj_pkg::N_L3];
  vrj_pkg::q_t p3 [vrj_pkg::N_L3];
  logic [vrj_pkg::N_L3-1:0] s3;
  vrj_pkg::ctx_t c3d, ctx3_r, ctx3_nxt;
  logic          v3d, v3_r;

  always_comb begin
    for (int i = 0; i < vrj_pkg::N_L3; i++) begin
      a3[i] = '0;
      b3[i] = '0;
    end
    s3 = '0;
    if (ctx2_r.op == vrj_pkg::OP_EPI) begin
      a3[0] = ctx2_r.x[1]; b3[0] = ctx2_r.c[2];
      a3[1] = ctx2_r.x[2]; b3[1] = ctx2_r.c[1];
      a3[2] = ctx2_r.x[2]; b3[2] = ctx2_r.c[0];
      a3[3] = ctx2_r.x[0]; b3[3] = ctx2_r.c[2];
      a3[4] = ctx2_r.x[0]; b3[4] = ctx2_r.c[1];
      a3[5] = ctx2_r.x[1]; b3[5] = ctx2_r.c[0];
    end else begin
      a3[0] = ctx2_r.u1; b3[0] = ctx2_r.s[2];
      a3[1] = ctx2_r.v1; b3[1] = ctx2_r.s[2];
      a3[2] = ctx2_r.u1; b3[2] = tz;
      a3[3] = ctx2_r.v1; b3[3] = tz;
      for (int k = 0; k < 3; k++) begin
        a3[4+k] = ctx2_r.u1; b3[4+k] = ctx2_r.c[6+k];
        a3[7+k] = ctx2_r.v1; b3[7+k] = ctx2_r.c[6+k];
      end
    end
  end

  vrj_mulbank #(.N(vrj_pkg::N_L3)) u_bank3 (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (v2_r),
    .ctx_in    (ctx2_r),
    .a         (a3),
    .b         (b3),
    .sel30     (s3),
    .p         (p3),
    .valid_out (v3d),
    .ctx_out   (c3d)
  );

  always_comb begin
    ctx3_nxt = c3d;
    if (c3d.op == vrj_pkg::OP_EPI) begin
      ctx3_nxt.ra.row_kind = vrj_pkg::KIND_EPI;
      ctx3_nxt.ra.last     = 1'b1;
      ctx3_nxt.ra.d_rx     = vrj_pkg::sat_sub(p3[0], p3[1]);
      ctx3_nxt.ra.d_ry     = vrj_pkg::sat_sub(p3[2], p3[3]);
      ctx3_nxt.ra.d_rz     = vrj_pkg::sat_sub(p3[4], p3[5]);
    end else begin
      // x row
      ctx3_nxt.ra.row_kind = vrj_pkg::KIND_X;
      ctx3_nxt.ra.last     = 1'b0;
      ctx3_nxt.ra.residual = vrj_pkg::sat_sub(
        vrj_pkg::sat_add(vrj_pkg::sat_sub(c3d.s[0], p3[0]), tx), p3[2]);
      ctx3_nxt.ra.d_tx     = vrj_pkg::ONE_Q16;
      ctx3_nxt.ra.d_ty     = '0;
      ctx3_nxt.ra.d_tz     = vrj_pkg::sat_sub('0, c3d.u1);
      ctx3_nxt.ra.d_rx     = vrj_pkg::sat_sub(c3d.c[0], p3[4]);
      ctx3_nxt.ra.d_ry     = vrj_pkg::sat_sub(c3d.c[1], p3[5]);
      ctx3_nxt.ra.d_rz     = vrj_pkg::sat_sub(c3d.c[2], p3[6]);
      // y row
      ctx3_nxt.rb.row_kind = vrj_pkg::KIND_Y;
      ctx3_nxt.rb.last     = 1'b1;
      ctx3_nxt.rb.residual = vrj_pkg::sat_sub(
        vrj_pkg::sat_add(vrj_pkg::sat_sub(c3d.s[1], p3[1]), ty), p3[3]);
      ctx3_nxt.rb.d_tx     = '0;
      ctx3_nxt.rb.d_ty     = vrj_pkg::ONE_Q16;
      ctx3_nxt.rb.d_tz     = vrj_pkg::sat_sub('0, c3d.v1);
      ctx3_nxt.rb.d_rx     = vrj_pkg::sat_sub(c3d.c[3], p3[7]);
      ctx3_nxt.rb.d_ry     = vrj_pkg::sat_sub(c3d.c[4], p3[8]);
      ctx3_nxt.rb.d_rz     = vrj_pkg::sat_sub(c3d.c[5], p3[9]);
    end
  end

  always_ff @(posedge clk) begin
    ctx3_r <= ctx3_nxt;
  end

  // valid bits of the add stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1d;
      v2_r <= v2d;
      v3_r <= v3d;
    end
  end

  // ---------------------------------------------------------------------
  // output: first row straight out, y row held for the next cycle in the hold register
  // ---------------------------------------------------------------------
  vrj_pkg::out_t out_r, out_nxt, hold_r, hold_nxt;
  logic          out_v_r, out_v_nxt, hold_v_r, hold_v_nxt;

  always_comb begin
    out_v_nxt  = 1'b0;
    out_nxt    = out_r;
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    if (v3_r) begin
      out_v_nxt  = 1'b1;
      out_nxt    = ctx3_r.ra;
      hold_v_nxt = (ctx3_r.op == vrj_pkg::OP_REPR);
      hold_nxt   = ctx3_r.rb;
    end else if (hold_v_r) begin
      out_v_nxt  = 1'b1;
      out_nxt    = hold_r;
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    hold_r <= hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      hold_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      hold_v_r <= hold_v_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_r;

  // checks
  `VRJ_ASSERT_NXT(a_busy_after_depth, start && !busy && (in_item.opcode == vrj_pkg::OP_REPR), busy)
  `VRJ_ASSERT_IMP(a_hold_no_clash, hold_v_r, !v3_r)
  `VRJ_ASSERT_NXT(a_y_follows_x, out_v_r && !out_r.last, out_v_r && (out_r.row_kind == vrj_pkg::KIND_Y))
  `VRJ_ASSERT_IMP(a_epi_is_last, out_v_r && (out_r.row_kind == vrj_pkg::KIND_EPI), out_r.last)

endmodule
